### sv/rmms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmms_pkg
// Types and constants shared by the rotation minimum-mismatch search block.
// ----------------------------------------------------------------------------
package rmms_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int SYM_W   = 8;
  localparam int CNT_W   = 7;
  localparam int LIM_W   = 7;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_a;
    logic [SYM_W-1:0] symbol_b;
    logic             last;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [5:0]       rotation;
    logic [CNT_W-1:0] mismatches;
    logic             overflow;
    logic             final_res;
  } out_word_t;

  typedef struct packed {
    logic shift_ab;
    logic count;
    logic clear;
    logic rot_cnt;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_COUNT,
    S_SCAN,
    S_EMIT
  } state_t;

endpackage

### sv/rmms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmms_cell
// One position of the search row: holds a symbol of each sequence and the
// mismatch count of one rotation; shifts all three toward the head.
// ----------------------------------------------------------------------------
module rmms_cell
  import rmms_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic             wr_en,
  input  logic             is_tail,
  input  logic [SYM_W-1:0] sym_a,
  input  logic [SYM_W-1:0] sym_b,
  input  logic [SYM_W-1:0] a_nb,
  input  logic [SYM_W-1:0] a_head,
  input  logic [SYM_W-1:0] b_nb,
  input  logic [SYM_W-1:0] b_bcast,
  input  logic [CNT_W-1:0] cnt_nb,
  input  logic [CNT_W-1:0] cnt_head,
  output logic [SYM_W-1:0] a,
  output logic [SYM_W-1:0] b,
  output logic [CNT_W-1:0] cnt
);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      a <= sym_a;
      b <= sym_b;
    end else if (ctl.shift_ab) begin
      a <= is_tail ? a_head : a_nb;
      b <= b_nb;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      cnt <= '0;
    end else if (ctl.count) begin
      cnt <= cnt + CNT_W'(a != b_bcast);
    end else if (ctl.rot_cnt) begin
      cnt <= is_tail ? cnt_head : cnt_nb;
    end
  end

endmodule

### sv/rmms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmms_ctrl
// Sequencer: load, count, minimum scan and result emission with output reg.
// ----------------------------------------------------------------------------
module rmms_ctrl
  import rmms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_wr_en,
  input  logic [LIM_W-1:0] cfg_wr_data,
  input  logic [CNT_W-1:0] cnt_head,
  output cell_ctl_t        ctl,
  output logic             load,
  output logic [IDX_W-1:0] wr_idx,
  output logic [IDX_W-1:0] tail_idx
);

  state_t           state, state_next;
  logic [LEN_W-1:0] fill, fill_next;
  logic             ovf, ovf_next;
  logic [LEN_W-1:0] step, step_next;
  logic [CNT_W-1:0] best, best_next;
  logic [LEN_W-1:0] ties, ties_next;
  logic [IDX_W-1:0] rot, rot_next;
  logic [LIM_W-1:0] allowed;
  logic             out_valid_next;
  out_word_t        out_word_next;
  logic             full;
  logic             at_end;
  logic             out_free;

  assign full     = (fill == LEN_W'(MAX_LEN));
  assign at_end   = (step == fill - LEN_W'(1));
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_LOAD);
  assign wr_idx   = fill[IDX_W-1:0];
  assign tail_idx = IDX_W'(fill - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      fill      <= '0;
      ovf       <= 1'b0;
      step      <= '0;
      best      <= '0;
      ties      <= '0;
      rot       <= '0;
      allowed   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      ovf       <= ovf_next;
      step      <= step_next;
      best      <= best_next;
      ties      <= ties_next;
      rot       <= rot_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        allowed <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word <= out_word_next;
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    ovf_next       = ovf;
    step_next      = step;
    best_next      = best;
    ties_next      = ties;
    rot_next       = rot;
    out_valid_next = out_valid && !out_ready;
    out_word_next  = out_word;
    ctl            = '0;
    load           = 1'b0;

    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          load      = !full;
          fill_next = full ? fill : fill + LEN_W'(1);
          ovf_next  = ovf | full;
          if (in_last) begin
            ctl.clear  = 1'b1;
            step_next  = '0;
            state_next = S_COUNT;
          end
        end
      end
      S_COUNT: begin
        ctl.count    = 1'b1;
        ctl.shift_ab = 1'b1;
        step_next    = step + LEN_W'(1);
        if (at_end) begin
          step_next  = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.rot_cnt = 1'b1;
        step_next   = step + LEN_W'(1);
        if (step == '0 || cnt_head < best) begin
          best_next = cnt_head;
          ties_next = LEN_W'(1);
        end else if (cnt_head == best) begin
          ties_next = ties + LEN_W'(1);
        end
        if (at_end) begin
          step_next  = '0;
          rot_next   = '0;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (LIM_W'(best) > allowed) begin
          if (out_free) begin
            out_valid_next           = 1'b1;
            out_word_next.found      = 1'b0;
            out_word_next.rotation   = '0;
            out_word_next.mismatches = best;
            out_word_next.overflow   = ovf;
            out_word_next.final_res  = 1'b1;
            fill_next                = '0;
            ovf_next                 = 1'b0;
            state_next               = S_LOAD;
          end
        end else if (cnt_head == best) begin
          if (out_free) begin
            out_valid_next           = 1'b1;
            out_word_next.found      = 1'b1;
            out_word_next.rotation   = rot;
            out_word_next.mismatches = best;
            out_word_next.overflow   = ovf;
            out_word_next.final_res  = (ties == LEN_W'(1));
            ctl.rot_cnt              = 1'b1;
            rot_next                 = rot + IDX_W'(1);
            ties_next                = ties - LEN_W'(1);
            if (ties == LEN_W'(1)) begin
              fill_next  = '0;
              ovf_next   = 1'b0;
              state_next = S_LOAD;
            end
          end
        end else begin
          ctl.rot_cnt = 1'b1;
          rot_next    = rot + IDX_W'(1);
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

### sv/rotation_min_mismatch_search_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_min_mismatch_search_top
// Cyclic rotation minimum-mismatch search over a row of symbol cells.
//
//   port group   dir   handshake            word
//   in_*         in    in_valid/in_ready    symbol_a, symbol_b, last
//   out_*        out   out_valid/out_ready  found, rotation, mismatches,
//                                           overflow, final_res
//   cfg_*        in    cfg_wr_en            allowed_mismatches
//
// Loading takes one word per cycle. After the last word the row counts
// mismatches (one reference symbol broadcast per cycle), then runs the
// minimum scan, then emits results, holding while the output stalls.
// in_ready is low during the search and rises as the final result is
// registered. Synchronous reset clears control only.
// ----------------------------------------------------------------------------
module rotation_min_mismatch_search_top
  import rmms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_word,
  input  logic             cfg_wr_en,
  input  logic [LIM_W-1:0] cfg_wr_data
);

  cell_ctl_t        ctl;
  logic             load;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] tail_idx;
  logic [SYM_W-1:0] a_q   [MAX_LEN];
  logic [SYM_W-1:0] b_q   [MAX_LEN];
  logic [CNT_W-1:0] cnt_q [MAX_LEN];

  rmms_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_last     (in_word.last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cnt_head    (cnt_q[0]),
    .ctl         (ctl),
    .load        (load),
    .wr_idx      (wr_idx),
    .tail_idx    (tail_idx)
  );

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    localparam int               NB = (j + 1) % MAX_LEN;
    localparam logic [IDX_W-1:0] ID = IDX_W'(j);

    rmms_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .wr_en    (load && (wr_idx == ID)),
      .is_tail  (tail_idx == ID),
      .sym_a    (in_word.symbol_a),
      .sym_b    (in_word.symbol_b),
      .a_nb     (a_q[NB]),
      .a_head   (a_q[0]),
      .b_nb     (b_q[NB]),
      .b_bcast  (b_q[0]),
      .cnt_nb   (cnt_q[NB]),
      .cnt_head (cnt_q[0]),
      .a        (a_q[j]),
      .b        (b_q[j]),
      .cnt      (cnt_q[j])
    );
  end

endmodule
